// ----- src/assert_macros.svh -----
// Assertion macros for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property, disabled while reset is asserted.
`define FIUD_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("fiud assertion failed");

// Clocked same-cycle implication, disabled while reset is asserted.
`define FIUD_ASSERT_IMPL(lbl, clk, rst_n, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error("fiud implication failed");

`endif

// ----- src/fiud_pkg.sv -----
// Shared constants, types and helpers of the fastest idle unit dispatcher.
`default_nettype none

package fiud_pkg;

  // Number of work units (1 to 8).
  localparam int NUM_UNITS = 4;
  // Number of per-unit time registers on the configuration port.
  localparam int REG_COUNT = 8;
  localparam int REG_IDX_W = 3;

  localparam int IDX_W      = (NUM_UNITS > 1) ? $clog2(NUM_UNITS) : 1;
  localparam int TIME_W     = 16;
  localparam int TASK_W     = 16;
  localparam int TICK_W     = 32;
  localparam int UNIT_OUT_W = 3;
  localparam int OUT_DATA_W = 40;
  localparam int CFG_ADDR_W = 5;
  localparam int CFG_DATA_W = 32;

  localparam logic [TIME_W-1:0] TIME_RESET = 16'd1;

  // Controller to datapath commands.
  typedef struct packed {
    logic             start;
    logic             scan;
    logic             scan_first;
    logic [IDX_W-1:0] scan_idx;
    logic             apply;
    logic             commit;
  } dp_cmd_t;

  // Datapath to controller status.
  typedef struct packed {
    logic out_free;
  } dp_sts_t;

  // 32-bit add that saturates at all ones.
  function automatic logic [TICK_W-1:0] sat_add32(input logic [TICK_W-1:0] a,
                                                  input logic [TICK_W-1:0] b);
    logic [TICK_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[TICK_W] ? {TICK_W{1'b1}} : s[TICK_W-1:0];
  endfunction

endpackage

`default_nettype wire

// ----- src/fiud_ctrl.sv -----
// Controller state machine: accept, unit scan, apply, commit.
`default_nettype none

module fiud_ctrl import fiud_pkg::*; (
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire logic    in_valid_i,
  output logic         in_ready_o,
  input  wire dp_sts_t sts_i,
  output dp_cmd_t      cmd_o
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_APPLY,
    ST_COMMIT
  } state_e;

  state_e           state_q;
  logic             ready_q;
  logic [IDX_W-1:0] idx_q;
  logic             last_unit;

  assign last_unit = (idx_q == IDX_W'(NUM_UNITS - 1));

  // State, scan counter and registered ready
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      ready_q <= 1'b0;
      idx_q   <= '0;
    end else begin
      case (state_q)
        ST_IDLE: begin
          ready_q <= 1'b1;
          if (in_valid_i && ready_q) begin
            ready_q <= 1'b0;
            idx_q   <= '0;
            state_q <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          if (last_unit) begin
            state_q <= ST_APPLY;
          end else begin
            idx_q <= idx_q + IDX_W'(1);
          end
        end
        ST_APPLY: begin
          state_q <= ST_COMMIT;
        end
        ST_COMMIT: begin
          if (sts_i.out_free) begin
            ready_q <= 1'b1;
            state_q <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
          ready_q <= 1'b0;
        end
      endcase
    end
  end

  assign in_ready_o = ready_q;

  // Command decode
  always_comb begin
    cmd_o            = '0;
    cmd_o.start      = (state_q == ST_IDLE) && in_valid_i && ready_q;
    cmd_o.scan       = (state_q == ST_SCAN);
    cmd_o.scan_first = (state_q == ST_SCAN) && (idx_q == '0);
    cmd_o.scan_idx   = idx_q;
    cmd_o.apply      = (state_q == ST_APPLY);
    cmd_o.commit     = (state_q == ST_COMMIT) && sts_i.out_free;
  end

endmodule

`default_nettype wire

// ----- src/fiud_dp.sv -----
// Datapath: unit times, busy countdowns, tick, scan, multiply, result register.
`default_nettype none

module fiud_dp import fiud_pkg::*; (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire dp_cmd_t               cmd_i,
  output dp_sts_t                    sts_o,
  input  wire logic [TASK_W-1:0]     task_count_i,
  input  wire logic                  cfg_we_i,
  input  wire logic [REG_IDX_W-1:0]  cfg_widx_i,
  input  wire logic [TIME_W-1:0]     cfg_wdata_i,
  input  wire logic [REG_IDX_W-1:0]  cfg_ridx_i,
  output logic      [TIME_W-1:0]     cfg_rdata_o,
  output logic                       out_valid_o,
  input  wire logic                  out_ready_i,
  output logic      [OUT_DATA_W-1:0] out_data_o
);

  logic [TIME_W-1:0]     unit_time_q [REG_COUNT];
  logic [TICK_W-1:0]     busy_q      [NUM_UNITS];
  logic [TICK_W-1:0]     tick_q;
  logic [TASK_W-1:0]     tasks_q;
  logic [TICK_W-1:0]     least_q;
  logic [IDX_W-1:0]      best_idx_q;
  logic [TIME_W-1:0]     best_time_q;
  logic [TICK_W-1:0]     prod_q;
  logic                  out_valid_q;
  logic [UNIT_OUT_W-1:0] out_unit_q;
  logic [TICK_W-1:0]     out_finish_q;

  logic [TICK_W-1:0]     cur_busy;
  logic [TIME_W-1:0]     cur_time;
  logic                  take;

  assign sts_o.out_free = !out_valid_q || out_ready_i;

  // Per-unit time registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < REG_COUNT; i++) begin
        unit_time_q[i] <= TIME_RESET;
      end
    end else if (cfg_we_i) begin
      unit_time_q[cfg_widx_i] <= cfg_wdata_i;
    end
  end

  assign cfg_rdata_o = unit_time_q[cfg_ridx_i];

  // Scan compare: least countdown first, then smallest time, lowest index
  assign cur_busy = busy_q[cmd_i.scan_idx];
  assign cur_time = unit_time_q[REG_IDX_W'(cmd_i.scan_idx)];
  assign take     = cmd_i.scan_first || (cur_busy < least_q) ||
                    ((cur_busy == least_q) && (cur_time < best_time_q));

  // Job registers, scan result and product
  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      tasks_q <= task_count_i;
    end
    if (cmd_i.scan && take) begin
      least_q     <= cur_busy;
      best_idx_q  <= cmd_i.scan_idx;
      best_time_q <= cur_time;
    end
    if (cmd_i.apply) begin
      prod_q <= {{(TICK_W-TIME_W){1'b0}}, best_time_q} *
                {{(TICK_W-TASK_W){1'b0}}, tasks_q};
    end
  end

  // Countdowns and tick: jump by the least countdown, then load the chosen unit
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_UNITS; i++) begin
        busy_q[i] <= '0;
      end
      tick_q <= '0;
    end else if (cmd_i.apply) begin
      for (int i = 0; i < NUM_UNITS; i++) begin
        busy_q[i] <= busy_q[i] - least_q;
      end
      tick_q <= sat_add32(tick_q, least_q);
    end else if (cmd_i.commit) begin
      busy_q[best_idx_q] <= prod_q;
    end
  end

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.commit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      out_unit_q   <= UNIT_OUT_W'(best_idx_q);
      out_finish_q <= sat_add32(tick_q, prod_q);
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = {{(OUT_DATA_W-TICK_W-UNIT_OUT_W){1'b0}}, out_finish_q, out_unit_q};

endmodule

`default_nettype wire

// ----- src/fastest_idle_unit_dispatcher.sv -----
// Top level of the fastest idle unit dispatcher.
// Each job request carries a task count and is handed to the idle work unit
// with the smallest per-task time (lowest index on ties); if no unit is idle,
// the tick clock jumps ahead by the smallest busy countdown so that one frees.
// The chosen unit's countdown becomes time * task_count and the result gives
// the unit and the finish tick (saturating at all ones). The scan visits
// one unit countdown per cycle; the apply state then jumps the countdowns
// and forms the product, and the commit state loads the chosen unit. Ready
// returns at commit, which waits while a result sits unaccepted in the
// output register. Unit times sit at APB byte address 4*i, reset to 1.
// Write them only while no job is in flight; the block does not enforce it.
`default_nettype none

module fastest_idle_unit_dispatcher import fiud_pkg::*; (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  // task_count[15:0]
  input  wire logic [TASK_W-1:0]     s_axis_tdata,
  input  wire logic                  s_axis_tvalid,
  output logic                       s_axis_tready,
  // unit_index[2:0], finish_tick[34:3], zero[39:35]
  output logic      [OUT_DATA_W-1:0] m_axis_tdata,
  output logic                       m_axis_tvalid,
  input  wire logic                  m_axis_tready,
  input  wire logic                  psel,
  input  wire logic                  penable,
  input  wire logic                  pwrite,
  input  wire logic [CFG_ADDR_W-1:0] paddr,
  input  wire logic [CFG_DATA_W-1:0] pwdata,
  output logic      [CFG_DATA_W-1:0] prdata,
  output logic                       pready
);

  dp_cmd_t           cmd;
  dp_sts_t           sts;
  logic [TIME_W-1:0] cfg_rdata;

  // APB decode: zero wait states
  assign pready = 1'b1;
  assign prdata = {{(CFG_DATA_W-TIME_W){1'b0}}, cfg_rdata};

  fiud_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  fiud_dp u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .task_count_i (s_axis_tdata),
    .cfg_we_i     (psel && penable && pwrite),
    .cfg_widx_i   (paddr[CFG_ADDR_W-1:2]),
    .cfg_wdata_i  (pwdata[TIME_W-1:0]),
    .cfg_ridx_i   (paddr[CFG_ADDR_W-1:2]),
    .cfg_rdata_o  (cfg_rdata),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .out_data_o   (m_axis_tdata)
  );

endmodule

`default_nettype wire

// ----- src/fiud_checker.sv -----
// Port-level checker for the dispatcher, bound to the top level.
`default_nettype none
`include "assert_macros.svh"

module fiud_checker import fiud_pkg::*; (
  input wire logic                  clk_i,
  input wire logic                  rst_ni,
  input wire logic [TASK_W-1:0]     s_axis_tdata,
  input wire logic                  s_axis_tvalid,
  input wire logic                  s_axis_tready,
  input wire logic [OUT_DATA_W-1:0] m_axis_tdata,
  input wire logic                  m_axis_tvalid,
  input wire logic                  m_axis_tready,
  input wire logic                  psel,
  input wire logic                  penable,
  input wire logic                  pwrite,
  input wire logic [CFG_ADDR_W-1:0] paddr,
  input wire logic [CFG_DATA_W-1:0] pwdata,
  input wire logic [CFG_DATA_W-1:0] prdata,
  input wire logic                  pready
);

  logic unused_ok;
  assign unused_ok = ^{s_axis_tdata, psel, penable, pwrite, paddr, pwdata, pready};

  // Reported unit is one that exists
  `FIUD_ASSERT_IMPL(a_unit_range, clk_i, rst_ni, m_axis_tvalid,
                    {1'b0, m_axis_tdata[2:0]} < 4'(NUM_UNITS))

  // Pad bits of the result and upper read data stay zero
  `FIUD_ASSERT_IMPL(a_pad_zero, clk_i, rst_ni, m_axis_tvalid || unused_ok || !unused_ok,
                    (m_axis_tdata[OUT_DATA_W-1:35] == '0) && (prdata[31:16] == '0))

  // One job at a time: ready drops right after an accept
  `FIUD_ASSERT(a_one_job, clk_i, rst_ni,
               (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)

  // A stalled result holds
  `FIUD_ASSERT(a_out_hold, clk_i, rst_ni,
               (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))

endmodule

bind fastest_idle_unit_dispatcher fiud_checker u_fiud_checker (.*);

`default_nettype wire

// ----- test/tb_top.sv -----
`timescale 1ns / 1ps
// Self-checking bench for the fastest idle unit dispatcher: APB setup, stream jobs, scoreboard.
module tb_top import fiud_pkg::*; ();

  localparam int CLK_PERIOD       = 4;
  localparam int DRAIN_CYCLES     = 16;
  localparam int LONG_HOLD_CYCLES = 400;
  localparam int JOBS_PER_PHASE   = 410;
  localparam int REPORT_LIMIT     = 10;
  localparam int UNIT_TIME_REG0   = 0;
  localparam int PAD_W            = OUT_DATA_W - UNIT_OUT_W - TICK_W;
  // keeps the tick clock clear of saturation until the final phase
  localparam longint unsigned LOAD_BUDGET = 64'd3_500_000_000;
  localparam logic [TIME_W-1:0] TIME_MAX  = '1;
  localparam logic [TASK_W-1:0] TASKS_MAX = '1;

  typedef enum int {
    TIMES_SMALL,
    TIMES_FULL,
    TIMES_EXTREME,
    TIMES_TIED,
    TIMES_SLOWEST
  } times_kind_e;

  typedef struct packed {
    logic [UNIT_OUT_W-1:0] unit;
    logic [TICK_W-1:0]     finish;
  } dispatch_t;

  // DUT connections
  logic                  clk_i;
  logic                  rst_ni        = 1'b0;
  logic [TASK_W-1:0]     s_axis_tdata  = '0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic                  psel          = 1'b0;
  logic                  penable       = 1'b0;
  logic                  pwrite        = 1'b0;
  logic [CFG_ADDR_W-1:0] paddr         = '0;
  logic [CFG_DATA_W-1:0] pwdata        = '0;
  logic [CFG_DATA_W-1:0] prdata;
  logic                  pready;

  // Stimulus control
  logic [TASK_W-1:0] job_q[$];
  int unsigned       src_idle_pct   = 0;
  int unsigned       sink_stall_pct = 0;
  logic              src_hold       = 1'b0;
  logic              sink_hold_go   = 1'b0;
  int unsigned       sink_hold_left;
  longint unsigned   load_spent     = 0;

  // Predictor state and expected results
  logic [TIME_W-1:0] unit_time_cfg [REG_COUNT];
  logic [TICK_W-1:0] unit_busy [NUM_UNITS];
  logic [TICK_W-1:0] tick_now;
  dispatch_t         dispatch_expect_q[$];
  int unsigned       mismatch_count = 0;

  fastest_idle_unit_dispatcher u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  initial begin
    clk_i = 1'b0;
    forever #(CLK_PERIOD / 2) clk_i = ~clk_i;
  end

  function automatic void note_mismatch(input string what);
    mismatch_count++;
    if (mismatch_count <= REPORT_LIMIT) $display("MISMATCH: %s", what);
  endfunction

  // tick addition that sticks at all ones
  function automatic logic [TICK_W-1:0] tick_plus(input logic [TICK_W-1:0] a,
                                                  input logic [TICK_W-1:0] b);
    logic [TICK_W-1:0] sum;
    sum = a + b;
    return (sum < a) ? '1 : sum;
  endfunction

  // Predict one dispatch and advance the mirrored unit state.
  function automatic dispatch_t dispatch_job(input logic [TASK_W-1:0] tasks);
    logic [TICK_W-1:0] least;
    logic [TICK_W-1:0] time_ext;
    logic [TICK_W-1:0] tasks_ext;
    logic [TICK_W-1:0] load;
    bit                any_idle;
    int                pick;
    int                u;
    dispatch_t         res;
    least    = '1;
    any_idle = 1'b0;
    pick     = -1;
    for (u = 0; u < NUM_UNITS; u++) begin
      if (unit_busy[u] == 0) any_idle = 1'b1;
      if (unit_busy[u] < least) least = unit_busy[u];
    end
    // all busy: jump ahead until the soonest unit frees
    if (!any_idle) begin
      for (u = 0; u < NUM_UNITS; u++) unit_busy[u] = unit_busy[u] - least;
      tick_now = tick_plus(tick_now, least);
    end
    // fastest idle unit, lowest index on ties
    for (u = 0; u < NUM_UNITS; u++) begin
      if (unit_busy[u] == 0 && (pick < 0 || unit_time_cfg[u] < unit_time_cfg[pick])) pick = u;
    end
    if (pick < 0) pick = 0;
    time_ext        = TICK_W'(unit_time_cfg[pick]);
    tasks_ext       = TICK_W'(tasks);
    load            = time_ext * tasks_ext;
    unit_busy[pick] = load;
    res.unit        = pick[UNIT_OUT_W-1:0];
    res.finish      = tick_plus(tick_now, load);
    return res;
  endfunction

  // Job driver: predicts on every accepted request
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= '0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        dispatch_expect_q = {dispatch_expect_q, dispatch_job(s_axis_tdata)};
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (job_q.size() != 0 && !src_hold && $urandom_range(99) >= src_idle_pct) begin
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= job_q.pop_front();
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // Long receiver hold-off, counted down here
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sink_hold_left <= 0;
    end else if (sink_hold_go) begin
      sink_hold_left <= LONG_HOLD_CYCLES;
    end else if (sink_hold_left != 0) begin
      sink_hold_left <= sink_hold_left - 1;
    end
  end

  // Result monitor and scoreboard
  always @(posedge clk_i or negedge rst_ni) begin
    dispatch_t             want;
    logic [UNIT_OUT_W-1:0] got_unit;
    logic [TICK_W-1:0]     got_finish;
    logic [PAD_W-1:0]      got_pad;
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        got_unit   = m_axis_tdata[UNIT_OUT_W-1:0];
        got_finish = m_axis_tdata[UNIT_OUT_W +: TICK_W];
        got_pad    = m_axis_tdata[OUT_DATA_W-1 -: PAD_W];
        if (dispatch_expect_q.size() == 0) begin
          note_mismatch($sformatf("result with nothing pending: tdata %h", m_axis_tdata));
        end else begin
          want = dispatch_expect_q.pop_front();
          if (got_unit !== want.unit)
            note_mismatch($sformatf("unit_index expected %0d got %0d", want.unit, got_unit));
          if (got_finish !== want.finish)
            note_mismatch($sformatf("finish_tick expected %h got %h", want.finish, got_finish));
          if (got_pad !== '0)
            note_mismatch($sformatf("tdata padding expected 0 got %h", got_pad));
        end
      end
      m_axis_tready <= (sink_hold_left == 0) && ($urandom_range(99) >= sink_stall_pct);
    end
  end

  // APB write with garbage in the unused upper bits, then read back
  task automatic cfg_write(input int idx, input logic [TIME_W-1:0] value);
    logic [CFG_DATA_W-1:0] noise;
    noise = $urandom;
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= CFG_ADDR_W'(4 * (UNIT_TIME_REG0 + idx));
    pwdata  <= {noise[CFG_DATA_W-1:TIME_W], value};
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    unit_time_cfg[idx] = value;
    @(posedge clk_i);
    psel <= 1'b1;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    if (prdata !== {{(CFG_DATA_W - TIME_W){1'b0}}, value})
      note_mismatch($sformatf("unit_time_%0d readback expected %h got %h", idx, value, prdata));
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic program_unit_times(input times_kind_e kind);
    logic [TIME_W-1:0] value;
    int                r;
    for (r = 0; r < REG_COUNT; r++) begin
      case (kind)
        TIMES_SMALL:   value = TIME_W'($urandom_range(16, 1));
        TIMES_FULL:    value = TIME_W'($urandom_range(TIME_MAX, 1));
        TIMES_TIED:    value = TIME_W'($urandom_range(3, 1));
        TIMES_SLOWEST: value = TIME_MAX;
        default: begin
          case ($urandom_range(2))
            0:       value = '0;
            1:       value = 16'd1;
            default: value = TIME_MAX;
          endcase
        end
      endcase
      cfg_write(r, value);
    end
  endtask

  // Queue a job; once the load budget is used up only tiny jobs go through
  task automatic queue_job(input logic [TASK_W-1:0] tasks);
    longint unsigned slowest;
    longint unsigned cost;
    int              u;
    slowest = 0;
    for (u = 0; u < NUM_UNITS; u++) begin
      if (64'(unit_time_cfg[u]) > slowest) slowest = 64'(unit_time_cfg[u]);
    end
    cost = slowest * 64'(tasks);
    if (load_spent + cost > LOAD_BUDGET) begin
      tasks = TASK_W'($urandom_range(1));
      cost  = slowest * 64'(tasks);
    end
    load_spent += cost;
    job_q = {job_q, tasks};
  endtask

  task automatic queue_random_jobs(input int n);
    logic [TASK_W-1:0] tasks;
    int unsigned       roll;
    repeat (n) begin
      roll = $urandom_range(99);
      if (roll < 5)       tasks = '0;
      else if (roll < 15) tasks = TASK_W'($urandom_range(TASKS_MAX));
      else if (roll < 40) tasks = TASK_W'($urandom_range(255));
      else                tasks = TASK_W'($urandom_range(15));
      queue_job(tasks);
    end
  endtask

  // Wait until every queued job is dispatched and every result is back
  task automatic drain();
    while (job_q.size() != 0 || s_axis_tvalid || dispatch_expect_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // Sequencer
  initial begin
    logic [TIME_W-1:0] times_zero_unit [REG_COUNT];
    logic [TIME_W-1:0] times_tie_unit  [REG_COUNT];
    int                r;
    int                phase;
    times_zero_unit = '{16'd9, 16'd3, 16'd0, 16'd3, TIME_MAX, 16'd0, 16'd1, 16'd2};
    times_tie_unit  = '{16'd4, 16'd2, 16'd2, TIME_MAX, 16'd1, TIME_MAX, 16'd0, 16'd7};
    for (r = 0; r < REG_COUNT; r++) unit_time_cfg[r] = TIME_RESET;
    for (r = 0; r < NUM_UNITS; r++) unit_busy[r] = '0;
    tick_now = '0;

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // reset times, all equal: lowest index wins, zero and full task counts
    queue_job('0);
    queue_job(TASKS_MAX);
    queue_job(16'd1);
    queue_job(16'd2);
    queue_job(16'd3);
    queue_job(16'd4);
    queue_job(16'h8000);
    queue_job(16'h00FF);
    queue_job(16'h5555);
    queue_job(16'hAAAA);
    drain();

    // a unit with zero time stays idle after each job it takes
    for (r = 0; r < REG_COUNT; r++) cfg_write(r, times_zero_unit[r]);
    queue_job(16'd5);
    queue_job(TASKS_MAX);
    queue_job(16'd1);
    drain();

    // tied fastest units, then waits for the soonest free unit
    for (r = 0; r < REG_COUNT; r++) cfg_write(r, times_tie_unit[r]);
    queue_job(16'd10);
    queue_job(16'd10);
    queue_job(16'd10);
    queue_job(16'd10);
    queue_job(16'd1);
    queue_job('0);
    queue_job(16'd2);
    drain();

    // random phases with different back-pressure and unit timing
    for (phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin
          src_idle_pct   = 0;
          sink_stall_pct = 0;
          program_unit_times(TIMES_SMALL);
        end
        1: begin
          src_idle_pct   = 76;
          sink_stall_pct = 0;
          program_unit_times(TIMES_FULL);
        end
        2: begin
          src_idle_pct   = 0;
          sink_stall_pct = 76;
          program_unit_times(TIMES_EXTREME);
        end
        default: begin
          src_idle_pct   = 35;
          sink_stall_pct = 35;
          program_unit_times(TIMES_TIED);
        end
      endcase
      queue_random_jobs(JOBS_PER_PHASE);
      if (phase == 0) begin
        // stall the output long enough for the input to back up
        while (job_q.size() > JOBS_PER_PHASE / 2) @(posedge clk_i);
        sink_hold_go <= 1'b1;
        @(posedge clk_i);
        sink_hold_go <= 1'b0;
      end else if (phase == 2) begin
        // sender pause until the block has emptied
        while (job_q.size() > JOBS_PER_PHASE / 2) @(posedge clk_i);
        src_hold <= 1'b1;
        @(posedge clk_i);
        while (s_axis_tvalid || dispatch_expect_q.size() != 0) @(posedge clk_i);
        src_hold <= 1'b0;
      end
      drain();
    end

    // slowest units with full jobs: the tick clock runs into saturation
    src_idle_pct   = 0;
    sink_stall_pct = 0;
    program_unit_times(TIMES_SLOWEST);
    repeat (6) job_q = {job_q, TASKS_MAX};
    job_q = {job_q, 16'd0};
    job_q = {job_q, 16'd1};
    job_q = {job_q, 16'h1234};
    drain();

    if (mismatch_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #2_000_000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule

// ----- filelist.f -----
+incdir+src
src/fiud_pkg.sv
src/fiud_ctrl.sv
src/fiud_dp.sv
src/fastest_idle_unit_dispatcher.sv
src/fiud_checker.sv
test/tb_top.sv
